// File: rtl/core/chte_pkg.sv
// Package with shared constants of the chained hash table engine.
`timescale 1ns / 1ps
package chte_pkg;
	localparam logic [63:0] HASH_BASIS = 64'h0000_0000_8422_2325;
	localparam logic [63:0] HASH_PRIME = 64'h0000_0000_0000_01b3;
	localparam int unsigned CFG_W = 9;
	localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 9'd256;
	localparam int unsigned HASH_ROUNDS = 8;
	localparam int unsigned MOD_BITS_PER_STEP = 4;
	localparam int unsigned MOD_STEPS = 64 / MOD_BITS_PER_STEP;
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_FIND = 1'b1;
endpackage

// File: rtl/core/chte_ifs.sv
// Valid/ready channel interfaces for command and result beats.
`timescale 1ns / 1ps
interface chte_in_if;
	logic valid;
	logic ready;
	logic cmd;
	logic signed [31:0] key;
	logic signed [31:0] value;
	modport source (output valid, cmd, key, value, input ready);
	modport sink (input valid, cmd, key, value, output ready);
endinterface

interface chte_out_if;
	logic valid;
	logic ready;
	logic found;
	logic signed [31:0] found_value;
	logic pool_full;
	modport source (output valid, found, found_value, pool_full, input ready);
	modport sink (input valid, found, found_value, pool_full, output ready);
endinterface

// File: rtl/core/chte_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module chte_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0] wdata,
	input  logic re,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: rtl/core/chte_front.sv
// Front end: accepts command beats, hashes the key, reduces it to a bucket.
`timescale 1ns / 1ps
module chte_front #(
	parameter int BUCKETS = 256,
	parameter int BW = 8
) (
	input  logic clk,
	input  logic arst_n,
	chte_in_if.sink in,
	input  logic [chte_pkg::CFG_W-1:0] bucket_count,
	output logic push,
	output logic [65+BW-1:0] push_data,
	input  logic push_ready
);
	typedef enum logic [1:0] {F_IDLE, F_HASH, F_MOD, F_PUSH} fstate_t;

	fstate_t state_q;
	logic [63:0] wide_q;
	logic [63:0] h_q;
	logic [3:0] cnt_q;
	logic [8:0] rem_q;
	logic cmd_q;
	logic [31:0] key_q;
	logic [31:0] val_q;
	logic [8:0] n;
	logic [8:0] rem_nx;
	logic [63:0] h_sh;
	logic [7:0] b;

	always_comb begin
		if (bucket_count == '0) begin
			n = 9'd1;
		end else if (32'(bucket_count) > BUCKETS) begin
			n = 9'(BUCKETS);
		end else begin
			n = bucket_count;
		end
	end

	always_comb begin
		logic [8:0] t;
		rem_nx = rem_q;
		h_sh = h_q;
		for (int j = 0; j < chte_pkg::MOD_BITS_PER_STEP; j++) begin
			t = {rem_nx[7:0], h_sh[63]};
			h_sh = {h_sh[62:0], 1'b0};
			if (t >= n) begin
				t = t - n;
			end
			rem_nx = t;
		end
	end

	assign b = wide_q[7:0];
	assign in.ready = (state_q == F_IDLE);
	assign push = (state_q == F_PUSH);
	assign push_data = {cmd_q, key_q, val_q, BW'(rem_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in.valid) begin
						cmd_q <= in.cmd;
						key_q <= in.key;
						val_q <= in.value;
						wide_q <= {{32{in.key[31]}}, in.key};
						cnt_q <= '0;
						rem_q <= '0;
						if (in.key[7:0] == 8'd0) begin
							h_q <= '0;
							state_q <= F_MOD;
						end else begin
							h_q <= chte_pkg::HASH_BASIS;
							state_q <= F_HASH;
						end
					end
				end
				F_HASH: begin
					if (b == 8'd0) begin
						cnt_q <= '0;
						state_q <= F_MOD;
					end else begin
						h_q <= (h_q ^ {56'd0, b}) * chte_pkg::HASH_PRIME;
						wide_q <= {8'd0, wide_q[63:8]};
						if (cnt_q == 4'(chte_pkg::HASH_ROUNDS - 1)) begin
							cnt_q <= '0;
							state_q <= F_MOD;
						end else begin
							cnt_q <= cnt_q + 4'd1;
						end
					end
				end
				F_MOD: begin
					rem_q <= rem_nx;
					h_q <= h_sh;
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(chte_pkg::MOD_STEPS - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/core/chte_fifo.sv
// Two-entry queue between the front and back ends.
`timescale 1ns / 1ps
module chte_fifo #(
	parameter int W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  logic [W-1:0] wdata,
	output logic wr_ready,
	input  logic rd,
	output logic [W-1:0] rdata,
	output logic rd_valid
);
	logic [W-1:0] mem_q [2];
	logic wp_q;
	logic rp_q;
	logic [1:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rdata = mem_q[rp_q];
	assign do_wr = wr && wr_ready;
	assign do_rd = rd && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= ~wp_q;
			end
			if (do_rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
		end
	end
endmodule

// File: rtl/core/chte_back.sv
// Back end: walks bucket chains, updates entries, allocates pool nodes.
`timescale 1ns / 1ps
module chte_back #(
	parameter int BUCKETS = 256,
	parameter int POOL_NODES = 32,
	parameter int BW = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  logic [65+BW-1:0] q_data,
	output logic q_pop,
	chte_out_if.source out
);
	localparam int NW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
	localparam int PW = $clog2(POOL_NODES + 1);
	localparam int EW = 65 + NW;

	typedef enum logic [1:0] {S_IDLE, S_CHK, S_LINK, S_DONE} bstate_t;

	bstate_t state_q;
	logic [BUCKETS-1:0] hv_q;
	logic [PW-1:0] pool_used_q;
	logic it_cmd_q;
	logic [31:0] it_key_q;
	logic [31:0] it_val_q;
	logic [BW-1:0] it_bkt_q;
	logic cur_head_q;
	logic [NW-1:0] cur_pidx_q;
	logic [NW-1:0] link_q;
	logic [EW-1:0] ent_q;
	logic p_found_q;
	logic [31:0] p_val_q;
	logic p_full_q;
	logic out_valid_q;
	logic out_found_q;
	logic [31:0] out_val_q;
	logic out_full_q;

	logic q_cmd;
	logic [31:0] q_key;
	logic [31:0] q_val;
	logic [BW-1:0] q_bkt;
	logic h_we, h_re, p_we, p_re;
	logic [BW-1:0] h_waddr;
	logic [NW-1:0] p_waddr, p_raddr;
	logic [EW-1:0] h_wdata, p_wdata, h_rdata, p_rdata, ent;
	logic [31:0] ek, ev;
	logic ehn;
	logic [NW-1:0] enx;
	logic e_match, e_tail, p_exh;
	logic [NW-1:0] pu;

	assign {q_cmd, q_key, q_val, q_bkt} = q_data;
	assign ent = cur_head_q ? h_rdata : p_rdata;
	assign ek = ent[EW-1 -: 32];
	assign ev = ent[EW-33 -: 32];
	assign ehn = ent[NW];
	assign enx = ent[NW-1:0];
	assign e_match = (ek == it_key_q);
	assign e_tail = !ehn || (32'(enx) >= POOL_NODES);
	assign p_exh = (32'(pool_used_q) >= POOL_NODES);
	assign pu = pool_used_q[NW-1:0];
	assign q_pop = (state_q == S_IDLE) && q_valid;

	always_comb begin
		h_we = 1'b0;
		h_re = 1'b0;
		p_we = 1'b0;
		p_re = 1'b0;
		h_waddr = it_bkt_q;
		h_wdata = {ek, ev, ehn, enx};
		p_waddr = cur_pidx_q;
		p_raddr = enx;
		p_wdata = {ek, it_val_q, ehn, enx};
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					if (hv_q[q_bkt]) begin
						h_re = 1'b1;
					end else if (q_cmd == chte_pkg::CMD_INSERT) begin
						h_we = 1'b1;
						h_waddr = q_bkt;
						h_wdata = {q_key, q_val, 1'b0, NW'(0)};
					end
				end
			end
			S_CHK: begin
				if (e_match) begin
					if (it_cmd_q == chte_pkg::CMD_INSERT) begin
						h_we = cur_head_q;
						p_we = !cur_head_q;
						h_wdata = {ek, it_val_q, ehn, enx};
					end
				end else if (e_tail) begin
					if (it_cmd_q == chte_pkg::CMD_INSERT && !p_exh) begin
						p_we = 1'b1;
						p_waddr = pu;
						p_wdata = {it_key_q, it_val_q, 1'b0, NW'(0)};
						h_we = cur_head_q;
						h_wdata = {ek, ev, 1'b1, pu};
					end
				end else begin
					p_re = 1'b1;
				end
			end
			S_LINK: begin
				p_we = 1'b1;
				p_wdata = {ent_q[EW-1 -: 64], 1'b1, link_q};
			end
			default: ;
		endcase
	end

	chte_ram #(.W(EW), .D(BUCKETS)) u_head (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.re(h_re), .raddr(q_bkt), .rdata(h_rdata)
	);

	chte_ram #(.W(EW), .D(POOL_NODES)) u_pool (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.re(p_re), .raddr(p_raddr), .rdata(p_rdata)
	);

	assign out.valid = out_valid_q;
	assign out.found = out_found_q;
	assign out.found_value = out_val_q;
	assign out.pool_full = out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hv_q <= '0;
			pool_used_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						it_cmd_q <= q_cmd;
						it_key_q <= q_key;
						it_val_q <= q_val;
						it_bkt_q <= q_bkt;
						cur_head_q <= 1'b1;
						p_found_q <= 1'b0;
						p_val_q <= '0;
						p_full_q <= 1'b0;
						if (hv_q[q_bkt]) begin
							state_q <= S_CHK;
						end else begin
							if (q_cmd == chte_pkg::CMD_INSERT) begin
								hv_q[q_bkt] <= 1'b1;
							end
							state_q <= S_DONE;
						end
					end
				end
				S_CHK: begin
					if (e_match) begin
						p_found_q <= 1'b1;
						if (it_cmd_q == chte_pkg::CMD_FIND) begin
							p_val_q <= ev;
						end
						state_q <= S_DONE;
					end else if (e_tail) begin
						state_q <= S_DONE;
						if (it_cmd_q == chte_pkg::CMD_INSERT) begin
							if (p_exh) begin
								p_full_q <= 1'b1;
							end else begin
								pool_used_q <= pool_used_q + PW'(1);
								ent_q <= ent;
								link_q <= pu;
								if (!cur_head_q) begin
									state_q <= S_LINK;
								end
							end
						end
					end else begin
						cur_head_q <= 1'b0;
						cur_pidx_q <= enx;
					end
				end
				S_LINK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out.ready) begin
						out_valid_q <= 1'b1;
						out_found_q <= p_found_q;
						out_val_q <= p_val_q;
						out_full_q <= p_full_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pool_used_q) <= POOL_NODES)
		else $error("pool count beyond pool size");
	a_pool_step: assert property (@(posedge clk) disable iff (!arst_n)
		pool_used_q != $past(pool_used_q) |-> pool_used_q == $past(pool_used_q) + PW'(1))
		else $error("pool count moved by more than one");
	a_link_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LINK |=> state_q == S_DONE)
		else $error("link write not followed by completion");
	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && p_full_q) |-> (it_cmd_q == chte_pkg::CMD_INSERT && !p_found_q))
		else $error("pool full flagged on a find or an update");
endmodule

// File: rtl/core/chained_hash_table_engine_top.sv
// Flow: the front end hashes the key with the one-round-a-cycle hash unit, then reduces it
// to a bucket with the 4-bit-a-cycle modulo unit. The back end fills or misses an empty
// bucket directly, or walks from the head through pool nodes (plus a link write into a pool
// node). The front end takes a new item once the last is queued; long chains limit the back end.
// Reset: asynchronous, active low; clears all bucket heads, the pool count and the queue,
// and sets bucket_count to 256. No clearing pass; items are taken right after reset.
`timescale 1ns / 1ps
module chained_hash_table_engine_top #(
	parameter int BUCKETS = 256,
	parameter int POOL_NODES = 32
) (
	input  logic clk,
	input  logic arst_n,
	chte_in_if.sink in,
	chte_out_if.source out,
	input  logic cfg_we,
	input  logic [chte_pkg::CFG_W-1:0] cfg_wdata
);
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

	logic [chte_pkg::CFG_W-1:0] bucket_count_q;
	logic push, push_ready, q_valid, q_pop;
	logic [65+BW-1:0] push_data, q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= chte_pkg::BUCKET_COUNT_RESET;
		end else if (cfg_we) begin
			bucket_count_q <= cfg_wdata;
		end
	end

	chte_front #(.BUCKETS(BUCKETS), .BW(BW)) u_front (
		.clk(clk), .arst_n(arst_n), .in(in), .bucket_count(bucket_count_q),
		.push(push), .push_data(push_data), .push_ready(push_ready)
	);

	chte_fifo #(.W(65 + BW)) u_fifo (
		.clk(clk), .arst_n(arst_n), .wr(push), .wdata(push_data), .wr_ready(push_ready),
		.rd(q_pop), .rdata(q_data), .rd_valid(q_valid)
	);

	chte_back #(.BUCKETS(BUCKETS), .POOL_NODES(POOL_NODES), .BW(BW)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
		.out(out)
	);
endmodule

// File: tb/chained_hash_table_engine_top_tb.sv
// Self-checking testbench of the chained hash table engine: random and directed beats.
`timescale 1ns / 1ps
module chained_hash_table_engine_top_tb;
	localparam int BUCKETS = 256;
	localparam int POOL_NODES = 32;
	localparam int LONG_HOLD = 400;

	typedef struct {
		logic cmd;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} table_cmd_t;

	typedef struct {
		logic found;
		logic signed [31:0] found_value;
		logic pool_full;
	} table_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [chte_pkg::CFG_W-1:0] cfg_wdata;

	chte_in_if in_ch();
	chte_out_if out_ch();

	chained_hash_table_engine_top #(.BUCKETS(BUCKETS), .POOL_NODES(POOL_NODES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch.sink),
		.out(out_ch.source),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	table_cmd_t cmd_q[$];
	table_result_t pending_results[$];
	logic signed [31:0] key_hist[$];
	int error_count = 0;
	int accepted_beats = 0;
	bit tail_quiet = 0;
	bit hold_done = 0;

	bit shadow_head_valid[BUCKETS];
	logic [31:0] shadow_key[BUCKETS + POOL_NODES];
	logic [31:0] shadow_val[BUCKETS + POOL_NODES];
	bit shadow_has_next[BUCKETS + POOL_NODES];
	int shadow_next[BUCKETS + POOL_NODES];
	int shadow_pool_used = 0;
	int shadow_buckets = 256;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic [63:0] fnv_hash(logic [31:0] k);
		logic [63:0] w;
		logic [63:0] h;
		logic [7:0] b;
		w = {{32{k[31]}}, k};
		h = chte_pkg::HASH_BASIS;
		if (w[7:0] == 8'd0)
			return 64'd0;
		for (int i = 0; i < 8; i++) begin
			b = w[8*i +: 8];
			if (b == 8'd0)
				break;
			h = (h ^ {56'd0, b}) * chte_pkg::HASH_PRIME;
		end
		return h;
	endfunction

	function automatic int bucket_of(logic [31:0] k);
		logic [63:0] n;
		n = shadow_buckets;
		if (n == 0)
			n = 1;
		if (n > BUCKETS)
			n = BUCKETS;
		return int'(fnv_hash(k) % n);
	endfunction

	// slots 0..BUCKETS-1 are heads, BUCKETS+i is pool node i
	function automatic table_result_t predict_lookup(table_cmd_t c);
		table_result_t r;
		int node;
		int b;
		r = '{found: 1'b0, found_value: 32'sd0, pool_full: 1'b0};
		b = bucket_of(c.key);
		if (c.cmd == chte_pkg::CMD_INSERT) begin
			if (!shadow_head_valid[b]) begin
				shadow_head_valid[b] = 1;
				shadow_key[b] = c.key;
				shadow_val[b] = c.value;
				shadow_has_next[b] = 0;
				shadow_next[b] = 0;
			end else begin
				node = b;
				for (int s = 0; s <= POOL_NODES; s++) begin
					if (shadow_key[node] == c.key) begin
						shadow_val[node] = c.value;
						r.found = 1'b1;
						break;
					end
					if (!shadow_has_next[node] || shadow_next[node] >= POOL_NODES) begin
						if (shadow_pool_used >= POOL_NODES) begin
							r.pool_full = 1'b1;
						end else begin
							shadow_key[BUCKETS + shadow_pool_used] = c.key;
							shadow_val[BUCKETS + shadow_pool_used] = c.value;
							shadow_has_next[BUCKETS + shadow_pool_used] = 0;
							shadow_next[BUCKETS + shadow_pool_used] = 0;
							shadow_has_next[node] = 1;
							shadow_next[node] = shadow_pool_used;
							shadow_pool_used++;
						end
						break;
					end
					node = BUCKETS + shadow_next[node];
				end
			end
		end else if (shadow_head_valid[b]) begin
			node = b;
			for (int s = 0; s <= POOL_NODES; s++) begin
				if (shadow_key[node] == c.key) begin
					r.found = 1'b1;
					r.found_value = shadow_val[node];
					break;
				end
				if (!shadow_has_next[node] || shadow_next[node] >= POOL_NODES)
					break;
				node = BUCKETS + shadow_next[node];
			end
		end
		return r;
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		table_cmd_t c;
		logic next_valid;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.cmd <= chte_pkg::CMD_INSERT;
			in_ch.key <= '0;
			in_ch.value <= '0;
			send_gap = 0;
		end else begin
			next_valid = in_ch.valid;
			if (in_ch.valid && in_ch.ready) begin
				c = '{cmd: in_ch.cmd, key: in_ch.key, value: in_ch.value};
				pending_results.push_back(predict_lookup(c));
				accepted_beats++;
				next_valid = 1'b0;
				if (!tail_quiet && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 13);
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (cmd_q.size() > 0) begin
					c = cmd_q.pop_front();
					in_ch.cmd <= c.cmd;
					in_ch.key <= c.key;
					in_ch.value <= c.value;
					next_valid = 1'b1;
				end
			end
			in_ch.valid <= next_valid;
		end
	end

	// monitor and receiver
	int recv_gap = 0;
	int hold_left = 0;
	always @(posedge clk or negedge arst_n) begin
		table_result_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result beat found=%0b value=%0d full=%0b",
						$time, out_ch.found, out_ch.found_value, out_ch.pool_full);
					error_count++;
				end else begin
					e = pending_results.pop_front();
					if (out_ch.found !== e.found) begin
						$display("%0t: found expected %0b actual %0b",
							$time, e.found, out_ch.found);
						error_count++;
					end
					if (out_ch.found_value !== e.found_value) begin
						$display("%0t: found_value expected %0d actual %0d",
							$time, e.found_value, out_ch.found_value);
						error_count++;
					end
					if (out_ch.pool_full !== e.pool_full) begin
						$display("%0t: pool_full expected %0b actual %0b",
							$time, e.pool_full, out_ch.pool_full);
						error_count++;
					end
				end
			end
			if (!hold_done && accepted_beats >= 200) begin
				hold_done = 1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ch.ready <= 1'b0;
			end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(1, 13) - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	function automatic logic signed [31:0] pick_key();
		case ($urandom_range(0, 9))
			0: return 32'sd0;
			1: return -32'sd1;
			2: return {24'($urandom_range(0, 32'hFFFFFF)), 8'h00};
			3: return $urandom_range(0, 300);
			4, 5, 6, 7: begin
				if (key_hist.size() > 0)
					return key_hist[$urandom_range(0, key_hist.size() - 1)];
				return $urandom;
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic push_cmd(logic cmd, logic signed [31:0] key, logic signed [31:0] value);
		cmd_q.push_back('{cmd: cmd, key: key, value: value});
		if (cmd == chte_pkg::CMD_INSERT)
			key_hist.push_back(key);
		if (key_hist.size() > 48)
			void'(key_hist.pop_front());
	endtask

	task automatic push_random(int count);
		for (int i = 0; i < count; i++)
			push_cmd(1'($urandom_range(0, 1)), pick_key(), $urandom);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (cmd_q.size() != 0 || in_ch.valid || pending_results.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_buckets(logic [chte_pkg::CFG_W-1:0] v);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		shadow_buckets = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		push_cmd(chte_pkg::CMD_FIND, 32'sd5, 32'sd0);
		push_cmd(chte_pkg::CMD_INSERT, 32'sd0, 32'sh7FFFFFFF);
		push_cmd(chte_pkg::CMD_INSERT, 32'sh00000100, 32'sh80000000);
		push_cmd(chte_pkg::CMD_FIND, 32'sd0, 32'sd0);
		push_cmd(chte_pkg::CMD_FIND, 32'sh00000100, 32'sd0);
		push_cmd(chte_pkg::CMD_INSERT, -32'sd1, -32'sd1);
		push_cmd(chte_pkg::CMD_INSERT, 32'sh7FFFFFFF, 32'sd1);
		push_cmd(chte_pkg::CMD_INSERT, 32'sh80000000, 32'sd0);
		push_cmd(chte_pkg::CMD_FIND, -32'sd1, 32'sd0);
		push_cmd(chte_pkg::CMD_FIND, 32'sh7FFFFFFF, 32'sd0);
		push_cmd(chte_pkg::CMD_FIND, 32'sh80000000, 32'sd0);
		push_cmd(chte_pkg::CMD_INSERT, -32'sd1, 32'sd42);
		push_cmd(chte_pkg::CMD_FIND, -32'sd1, 32'sd0);
		push_cmd(chte_pkg::CMD_FIND, 32'sd77, 32'sd0);

		write_buckets(9'd0);
		for (int i = 1; i <= 6; i++)
			push_cmd(chte_pkg::CMD_INSERT, i, -i);
		push_cmd(chte_pkg::CMD_FIND, 32'sd3, 32'sd0);
		push_cmd(chte_pkg::CMD_FIND, -32'sd1, 32'sd0);

		write_buckets(9'd511);
		push_random(60);
		write_buckets(9'd1);
		push_random(60);
		write_buckets(9'd3);
		push_random(200);
		write_buckets(9'd256);
		push_random(250);
		wait_drained();
		write_buckets(9'd7);
		push_random(200);
		write_buckets(9'd256);
		tail_quiet = 1;
		push_random(100);

		wait_drained();
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("** chained_hash_table_engine_top: PASSED **");
		else
			$display("** chained_hash_table_engine_top: FAILED **");
		$finish;
	end

	initial begin
		#2000000;
		$display("** chained_hash_table_engine_top: FAILED **");
		$finish;
	end
endmodule

// File: filelist.f
rtl/core/chte_pkg.sv
rtl/core/chte_ifs.sv
rtl/core/chte_ram.sv
rtl/core/chte_front.sv
rtl/core/chte_fifo.sv
rtl/core/chte_back.sv
rtl/core/chained_hash_table_engine_top.sv
tb/chained_hash_table_engine_top_tb.sv
